[design/dpf_pkg.sv]
// Shared types and constants for the fp32 dot product block.
`default_nettype none
package dpf_pkg;
	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [31:0] POS_INF   = 32'h7F80_0000;
	localparam logic [31:0] ONE_F     = 32'h3F80_0000;

	// operand classification
	typedef struct packed {
		logic is_nan;
		logic is_inf;
		logic is_zero;
	} fcls_t;

	function automatic fcls_t classify(input logic [31:0] x);
		fcls_t c;
		c.is_nan  = (x[30:0] > POS_INF[30:0]);
		c.is_inf  = (x[30:0] == POS_INF[30:0]);
		c.is_zero = (x[30:0] == 31'd0);
		return c;
	endfunction
endpackage
`default_nettype wire

[design/dpf_stream_if.sv]
// Valid/ready stream interface with a parameterized payload.
`default_nettype none
interface dpf_stream_if #(
	parameter int unsigned WIDTH = 32
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/dpf_fma.sv]
// Multi-cycle single-precision fused multiply-add with one rounding.
`default_nettype none
module dpf_fma
	import dpf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	input  wire logic [31:0] c,
	output logic             done,
	output logic [31:0]      result
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_ALIGN = 3'd2;
	localparam logic [2:0] ST_ADD   = 3'd3;
	localparam logic [2:0] ST_NORM  = 3'd4;
	localparam logic [2:0] ST_RND   = 3'd5;

	logic [2:0]  state_q;
	logic [31:0] a_q, b_q, c_q;
	logic [47:0] prod_q;
	logic signed [11:0] ep_q, ec_q;
	logic [63:0] big_q, small_q, sum_q;
	logic        sp_q, sc_q, s_q;
	logic        cz_q;
	logic signed [11:0] e_q;
	logic [5:0]  lz_q;

	fcls_t ca, cb, cc;
	logic [23:0] ma, mb, mc;
	logic signed [11:0] ea, eb, ec;
	logic        special;
	logic [31:0] special_val;
	logic [5:0]  top_p, top_c, top_s;
	logic signed [11:0] dexp;
	logic [63:0] p_n, c_n, far, jam_v;
	logic [6:0]  dsh;
	logic signed [12:0] sh;
	logic [63:0] q, rem, half;
	logic signed [13:0] word;
	logic        rnd_up;

	// classify operands and resolve special values
	always_comb begin
		ca = classify(a);
		cb = classify(b);
		cc = classify(c);
		special = 1'b1;
		special_val = 32'd0;
		if (ca.is_nan || cb.is_nan || cc.is_nan) begin
			special_val = CANON_NAN;
		end else if (ca.is_inf || cb.is_inf) begin
			if (ca.is_zero || cb.is_zero) special_val = CANON_NAN;
			else if (cc.is_inf && (c[31] != (a[31] ^ b[31]))) special_val = CANON_NAN;
			else special_val = {a[31] ^ b[31], POS_INF[30:0]};
		end else if (cc.is_inf) begin
			special_val = c;
		end else if (ca.is_zero || cb.is_zero) begin
			if (cc.is_zero) special_val = ((a[31] ^ b[31]) == c[31]) ? c : 32'd0;
			else special_val = c;
		end else begin
			special = 1'b0;
		end
	end

	function automatic logic [23:0] mant(input logic [31:0] x);
		return (x[30:23] == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
	endfunction
	function automatic logic signed [11:0] expo(input logic [31:0] x);
		return (x[30:23] == 8'd0) ? -12'sd149 : ($signed({4'd0, x[30:23]}) - 12'sd150);
	endfunction
	function automatic logic [5:0] msb64(input logic [63:0] v);
		logic [5:0] k;
		k = 6'd0;
		for (int i = 0; i < 64; i++) if (v[i]) k = 6'(i);
		return k;
	endfunction

	assign ma = mant(a_q);
	assign mb = mant(b_q);
	assign mc = mant(c_q);
	assign ea = expo(a_q);
	assign eb = expo(b_q);
	assign ec = expo(c_q);

	// normalize product and addend to bit 61
	always_comb begin
		top_p = msb64({16'd0, prod_q});
		top_c = msb64({40'd0, mc});
		p_n = {16'd0, prod_q} << (6'd61 - top_p);
		c_n = {40'd0, mc} << (6'd61 - top_c);
		dexp = (ep_q - $signed({6'd0, 6'd61 - top_p}))
			- (ec - $signed({6'd0, 6'd61 - top_c}));
	end

	// sticky right shift of the smaller operand
	always_comb begin
		far = (dexp >= 0) ? c_n : p_n;
		if (dexp >= 0) dsh = (dexp >= 12'sd63) ? 7'd63 : 7'(dexp);
		else dsh = (dexp <= -12'sd63) ? 7'd63 : 7'(-dexp);
		if (dsh >= 7'd63) jam_v = {63'd0, far != 64'd0};
		else jam_v = (far >> dsh) | {63'd0, (far & ((64'd1 << dsh) - 64'd1)) != 64'd0};
	end

	// round sum_q * 2^e_q to single
	always_comb begin
		top_s = lz_q;
		sh = $signed({7'd0, top_s}) - 13'sd23;
		if ((-13'sd149 - 13'(e_q)) > sh) sh = -13'sd149 - 13'(e_q);
		q = 64'd0;
		rem = 64'd0;
		half = 64'd0;
		rnd_up = 1'b0;
		if (sh <= 0) begin
			q = sum_q << 6'(-sh);
		end else if (sh < 13'sd64) begin
			rem = sum_q & ((64'd1 << 6'(sh)) - 64'd1);
			half = 64'd1 << 6'(sh - 13'sd1);
			q = sum_q >> 6'(sh);
			rnd_up = (rem > half) || ((rem == half) && q[0]);
		end
		q = q + {63'd0, rnd_up};
		word = 14'(e_q) + 14'(sh) + 14'sd149;
	end

	logic [37:0] wsum;
	assign wsum = $signed({{24{word[13]}}, word}) * 38'sd8388608 + $signed({13'd0, q[24:0]});

	// sequence the operation one step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						a_q <= a;
						b_q <= b;
						c_q <= c;
						sp_q <= a[31] ^ b[31];
						sc_q <= c[31];
						cz_q <= cc.is_zero;
						if (special) begin
							result <= special_val;
							done <= 1'b1;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					prod_q <= ma * mb;
					ep_q <= ea + eb;
					state_q <= ST_ALIGN;
				end
				ST_ALIGN: begin
					if (cz_q) begin
						sum_q <= {16'd0, prod_q};
						e_q <= ep_q;
						s_q <= sp_q;
						state_q <= ST_NORM;
					end else begin
						big_q <= (dexp >= 0) ? p_n : c_n;
						small_q <= jam_v;
						s_q <= (dexp >= 0) ? sp_q : sc_q;
						e_q <= (dexp >= 0) ? (ep_q - $signed({6'd0, 6'd61 - top_p}))
							: (ec - $signed({6'd0, 6'd61 - top_c}));
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (sp_q == sc_q) sum_q <= big_q + small_q;
					else if (big_q >= small_q) sum_q <= big_q - small_q;
					else begin
						sum_q <= small_q - big_q;
						s_q <= ~s_q;
					end
					state_q <= ST_NORM;
				end
				ST_NORM: begin
					if (sum_q == 64'd0) begin
						result <= 32'd0;
						done <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						lz_q <= msb64(sum_q);
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					if (wsum[37] == 1'b0 && wsum >= 38'(POS_INF))
						result <= {s_q, POS_INF[30:0]};
					else
						result <= {s_q, wsum[30:0]};
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[design/fp32_dot_product_fma.sv]
// Top level: streaming fp32 dot product over interleaved FMA lane sums.
// Usage:
//   in_word  carries {last, b_value, a_value}; an item is taken when
//   valid and ready are both high. Each item updates lane sum
//   (position mod LANES) with a fused multiply-add read from and written
//   back to a lane memory with a registered read.
//   out_word carries dot_result and appears only for an item with last set:
//   the lanes are then summed in order 0..LANES-1 starting from +0, the
//   result is held in an output register, and lanes and position clear.
// Sequencing:
//   each accumulate item goes through accept, memory read, FMA start,
//   then the shared FMA sequencer, where special operands skip the
//   arithmetic steps; the next item is taken only after that. A last item
//   adds LANES passes through that same unit, an emit step and a clear
//   sweep of the lane memory.
// Reset:
//   arst_n clears control; a clearing pass writes +0 to every lane
//   before the first item is taken.
// Stall:
//   while a result waits in the output register, the next item is still
//   taken and accumulated; a second result waits until the first is taken.
`default_nettype none
module fp32_dot_product_fma
	import dpf_pkg::*;
#(
	parameter int unsigned LANES = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dpf_stream_if.sink   in_word,
	dpf_stream_if.source out_word
);
	localparam int unsigned LW = (LANES > 1) ? $clog2(LANES) : 1;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_READ  = 4'd2;
	localparam logic [3:0] ST_FMA   = 4'd3;
	localparam logic [3:0] ST_WAIT  = 4'd4;
	localparam logic [3:0] ST_RRD   = 4'd5;
	localparam logic [3:0] ST_RFMA  = 4'd6;
	localparam logic [3:0] ST_RWAIT = 4'd7;
	localparam logic [3:0] ST_EMIT  = 4'd8;

	logic [31:0] lane_mem [LANES];
	logic [31:0] rd_q;
	logic          we;
	logic [LW-1:0] wa, ra;
	logic [31:0]   wd;

	logic [3:0]    state_q;
	logic [LW-1:0] pos_q, idx_q;
	logic [31:0]   a_q, b_q, total_q;
	logic          last_q;
	logic          fma_start;
	logic [31:0]   fa, fb, fc, fres;
	logic          fdone;
	logic          ovalid_q;
	logic [31:0]   odata_q;

	// lane memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (we) lane_mem[wa] <= wd;
		rd_q <= lane_mem[ra];
	end

	dpf_fma u_fma (
		.clk(clk), .arst_n(arst_n), .start(fma_start),
		.a(fa), .b(fb), .c(fc), .done(fdone), .result(fres)
	);

	function automatic logic [LW-1:0] wrap_inc(input logic [LW-1:0] v);
		return (32'(v) == LANES - 1) ? '0 : LW'(32'(v) + 1);
	endfunction

	// control datapath selects
	always_comb begin
		we = 1'b0;
		wa = idx_q;
		wd = fres;
		ra = idx_q;
		fma_start = 1'b0;
		fa = a_q;
		fb = b_q;
		fc = rd_q;
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				wd = 32'd0;
			end
			ST_FMA, ST_RFMA: fma_start = 1'b1;
			ST_WAIT: we = fdone;
			default: ;
		endcase
		if (state_q == ST_RFMA) begin
			fa = rd_q;
			fb = ONE_F;
			fc = total_q;
		end
	end

	assign in_word.ready = (state_q == ST_IDLE);
	assign out_word.valid = ovalid_q;
	assign out_word.data = odata_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q <= '0;
			pos_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			// drop a taken result word unless a new one loads now
			if (out_word.valid && out_word.ready && state_q != ST_EMIT) ovalid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					idx_q <= wrap_inc(idx_q);
					if (32'(idx_q) == LANES - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_word.valid) begin
						a_q <= in_word.data[31:0];
						b_q <= in_word.data[63:32];
						last_q <= in_word.data[64];
						idx_q <= pos_q;
						pos_q <= wrap_inc(pos_q);
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_FMA;
				ST_FMA: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (fdone) begin
						if (last_q) begin
							idx_q <= '0;
							total_q <= 32'd0;
							state_q <= ST_RRD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_RRD: state_q <= ST_RFMA;
				ST_RFMA: state_q <= ST_RWAIT;
				ST_RWAIT: begin
					if (fdone) begin
						total_q <= fres;
						if (32'(idx_q) == LANES - 1) state_q <= ST_EMIT;
						else begin
							idx_q <= wrap_inc(idx_q);
							state_q <= ST_RRD;
						end
					end
				end
				ST_EMIT: begin
					if (!ovalid_q || out_word.ready) begin
						ovalid_q <= 1'b1;
						odata_q <= total_q;
						pos_q <= '0;
						idx_q <= '0;
						state_q <= ST_CLEAR;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end
endmodule
`default_nettype wire

[design/dpf_checker.sv]
// Port-level checker for the dot product block, bound to the top level.
`default_nettype none
module dpf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] out_data
);
	// hold a stalled result word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed under stall");
	// no input taken right out of reset
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !in_ready)
		else $error("input ready during clear pass");
	// an accepted word starts work: ready drops
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while busy");
	// result appears only after work, not with an acceptance
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result raised on acceptance");
endmodule

bind fp32_dot_product_fma dpf_checker u_dpf_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_word.valid), .in_ready(in_word.ready),
	.out_valid(out_word.valid), .out_ready(out_word.ready),
	.out_data(out_word.data)
);
`default_nettype wire
